// ===== design/dlc_pkg.sv =====
// Shared types, codes and the microcode table of the display list coprocessor.
package dlc_pkg;

    localparam int STEP_W = 5;
    localparam int PC_W   = 24;

    // Request codes on i_action.
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_SLOT  = 2'd2;
    localparam logic [1:0] ACT_LOAD  = 2'd3;

    // Opcode classes; anything above OP_JUMP behaves as OP_END.
    localparam logic [1:0] OP_END  = 2'd0;
    localparam logic [1:0] OP_WAIT = 2'd1;
    localparam logic [1:0] OP_MOVE = 2'd2;
    localparam logic [1:0] OP_JUMP = 2'd3;

    // Microprogram step addresses.
    localparam logic [STEP_W-1:0] ST_DISP  = 5'd0;
    localparam logic [STEP_W-1:0] ST_CLR   = 5'd1;
    localparam logic [STEP_W-1:0] ST_START = 5'd2;
    localparam logic [STEP_W-1:0] ST_SLOT  = 5'd3;
    localparam logic [STEP_W-1:0] ST_LOAD  = 5'd4;
    localparam logic [STEP_W-1:0] ST_MUL1  = 5'd5;
    localparam logic [STEP_W-1:0] ST_MUL2  = 5'd6;
    localparam logic [STEP_W-1:0] ST_MODF  = 5'd7;
    localparam logic [STEP_W-1:0] ST_STORE = 5'd8;
    localparam logic [STEP_W-1:0] ST_CHK   = 5'd9;
    localparam logic [STEP_W-1:0] ST_OPC   = 5'd10;
    localparam logic [STEP_W-1:0] ST_END   = 5'd11;
    localparam logic [STEP_W-1:0] ST_WAIT1 = 5'd12;
    localparam logic [STEP_W-1:0] ST_MOVE1 = 5'd13;
    localparam logic [STEP_W-1:0] ST_JUMP1 = 5'd14;
    localparam logic [STEP_W-1:0] ST_WAIT2 = 5'd15;
    localparam logic [STEP_W-1:0] ST_WAIT3 = 5'd16;
    localparam logic [STEP_W-1:0] ST_WAIT4 = 5'd17;
    localparam logic [STEP_W-1:0] ST_WAITF = 5'd18;
    localparam logic [STEP_W-1:0] ST_MOVE2 = 5'd19;
    localparam logic [STEP_W-1:0] ST_MOVEF = 5'd20;
    localparam logic [STEP_W-1:0] ST_JUMP2 = 5'd21;
    localparam logic [STEP_W-1:0] ST_JUMP3 = 5'd22;
    localparam logic [STEP_W-1:0] ST_JUMPF = 5'd23;
    localparam logic [STEP_W-1:0] ST_DONE  = 5'd24;

    typedef enum logic [3:0] {
        U_NOP,
        U_BEGIN,
        U_CLEAR,
        U_START,
        U_LDARG,
        U_MUL1,
        U_MUL2,
        U_MODFIN,
        U_STORE,
        U_SLOT,
        U_OPCODE,
        U_STOP,
        U_TAKE,
        U_TAKE_LINE,
        U_WAITFIN,
        U_MOVEFIN
    } t_uop;

    typedef enum logic [2:0] {
        J_NEXT,
        J_ALWAYS,
        J_CASE_ACT,
        J_CASE_OP,
        J_IF_NOT_LOAD,
        J_IF_UNWANTED,
        J_RETIRE
    } t_jump;

    typedef struct packed {
        t_uop              op;
        t_jump             jmp;
        logic [STEP_W-1:0] target;
    } t_uword;

    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{op: U_NOP, jmp: J_ALWAYS, target: ST_DONE};
        case (step)
            ST_DISP:  w = '{op: U_BEGIN,     jmp: J_CASE_ACT,    target: ST_CLR};
            ST_CLR:   w = '{op: U_CLEAR,     jmp: J_ALWAYS,      target: ST_DONE};
            ST_START: w = '{op: U_START,     jmp: J_ALWAYS,      target: ST_MUL1};
            ST_SLOT:  w = '{op: U_SLOT,      jmp: J_ALWAYS,      target: ST_CHK};
            ST_LOAD:  w = '{op: U_LDARG,     jmp: J_ALWAYS,      target: ST_MUL1};
            ST_MUL1:  w = '{op: U_MUL1,      jmp: J_NEXT,        target: ST_MUL2};
            ST_MUL2:  w = '{op: U_MUL2,      jmp: J_NEXT,        target: ST_MODF};
            ST_MODF:  w = '{op: U_MODFIN,    jmp: J_IF_NOT_LOAD, target: ST_DONE};
            ST_STORE: w = '{op: U_STORE,     jmp: J_ALWAYS,      target: ST_DONE};
            ST_CHK:   w = '{op: U_NOP,       jmp: J_IF_UNWANTED, target: ST_DONE};
            ST_OPC:   w = '{op: U_OPCODE,    jmp: J_CASE_OP,     target: ST_END};
            ST_END:   w = '{op: U_STOP,      jmp: J_ALWAYS,      target: ST_DONE};
            ST_WAIT1: w = '{op: U_TAKE,      jmp: J_ALWAYS,      target: ST_WAIT2};
            ST_MOVE1: w = '{op: U_TAKE,      jmp: J_ALWAYS,      target: ST_MOVE2};
            ST_JUMP1: w = '{op: U_TAKE,      jmp: J_ALWAYS,      target: ST_JUMP2};
            ST_WAIT2: w = '{op: U_TAKE,      jmp: J_NEXT,        target: ST_WAIT3};
            ST_WAIT3: w = '{op: U_TAKE_LINE, jmp: J_NEXT,        target: ST_WAIT4};
            ST_WAIT4: w = '{op: U_TAKE,      jmp: J_NEXT,        target: ST_WAITF};
            ST_WAITF: w = '{op: U_WAITFIN,   jmp: J_ALWAYS,      target: ST_DONE};
            ST_MOVE2: w = '{op: U_TAKE,      jmp: J_NEXT,        target: ST_MOVEF};
            ST_MOVEF: w = '{op: U_MOVEFIN,   jmp: J_ALWAYS,      target: ST_DONE};
            ST_JUMP2: w = '{op: U_TAKE,      jmp: J_NEXT,        target: ST_JUMP3};
            ST_JUMP3: w = '{op: U_TAKE,      jmp: J_NEXT,        target: ST_JUMPF};
            ST_JUMPF: w = '{op: U_NOP,       jmp: J_ALWAYS,      target: ST_MUL1};
            ST_DONE:  w = '{op: U_NOP,       jmp: J_RETIRE,      target: ST_DISP};
            default:  w = '{op: U_NOP,       jmp: J_ALWAYS,      target: ST_DONE};
        endcase
        return w;
    endfunction

endpackage

// ===== design/display_list_coprocessor.sv =====
// Display list coprocessor: microcoded sequencer, program store and beam compare.
// busy stays high through o_done, so a new request is accepted only after the last one
//   retires; the microprogram takes one program byte per fetch step and uses three steps
//   per address reduction.
// Synchronous active-low reset clears the sequencer, control and output registers but not
//   the program store, the operand registers or the captured request; o_done cannot stall.
module display_list_coprocessor #(
    parameter int PROGRAM_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_beam_x,
    input  logic [15:0] i_beam_y,
    input  logic [23:0] i_address,
    input  logic [7:0]  i_load_byte,
    output logic        o_done,
    output logic        o_slot_wanted,
    output logic        o_executed,
    output logic        o_write_valid,
    output logic [15:0] o_write_address,
    output logic [7:0]  o_write_value,
    output logic        o_running,
    output logic        o_holding,
    output logic [23:0] o_program_counter,
    output logic [31:0] o_instruction_count
);

    localparam int AW    = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
    localparam int SHIFT = dlc_pkg::PC_W + AW;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + 64'(PROGRAM_DEPTH) - 64'd1) / 64'(PROGRAM_DEPTH);
    localparam logic [24:0] RECIP   = 25'(RECIP_L);
    localparam logic [24:0] DEPTH_C = 25'(PROGRAM_DEPTH);
    localparam logic [AW-1:0] IDX_LAST = AW'(PROGRAM_DEPTH - 1);

    logic [7:0] r_mem [PROGRAM_DEPTH];
    logic [7:0] r_rdata;

    logic                      r_active, n_active;
    logic [dlc_pkg::STEP_W-1:0] r_step, n_step;

    logic [1:0]  r_act;
    logic [15:0] r_bx, r_by;
    logic [23:0] r_addr;
    logic [7:0]  r_lb;

    logic [23:0]   r_pc, n_pc;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_widx, n_widx;
    logic          r_en, n_en;
    logic          r_wait, n_wait;
    logic [15:0]   r_tline, n_tline;
    logic [15:0]   r_tcol, n_tcol;
    logic [31:0]   r_total, n_total;

    logic [23:0] r_buf, n_buf;
    logic [23:0] r_modarg, n_modarg;
    logic [48:0] r_prod, n_prod;
    logic [23:0] r_qd, n_qd;

    logic        r_wanted, n_wanted;
    logic        r_exec, n_exec;
    logic        r_wr, n_wr;
    logic [15:0] r_wa, n_wa;
    logic [7:0]  r_wv, n_wv;

    dlc_pkg::t_uword w_uw;
    logic        w_accept;
    logic        w_store;
    logic [1:0]  w_op_class;
    logic        w_slot_reached;
    logic        w_wait_reached;
    logic [AW-1:0] w_idx_inc;
    logic [23:0] w_quot;
    logic [48:0] w_qd_full;

    assign w_uw     = dlc_pkg::ucode(r_step);
    assign w_accept = start && !busy;
    assign w_store  = r_active && (w_uw.op == dlc_pkg::U_STORE);

    assign w_op_class = (r_rdata > 8'(dlc_pkg::OP_JUMP)) ? dlc_pkg::OP_END : r_rdata[1:0];

    assign w_slot_reached = (r_by > r_tline) || ((r_by == r_tline) && (r_bx >= r_tcol));
    assign w_wait_reached = (r_by > r_tline) ||
                            ((r_by == r_tline) && (r_bx >= r_buf[23:8]));

    // Store index follows the program counter; the last store entry or a 24-bit wrap restarts it at zero.
    assign w_idx_inc = ((r_pc == 24'hFFFFFF) || (r_idx == IDX_LAST)) ? '0
                                                                    : AW'(r_idx + 1'b1);

    assign w_quot    = 24'(r_prod >> SHIFT);
    assign w_qd_full = 49'(w_quot) * 49'(DEPTH_C);

    always_comb begin
        n_active = r_active;
        n_step   = r_step;
        n_pc     = r_pc;
        n_idx    = r_idx;
        n_widx   = r_widx;
        n_en     = r_en;
        n_wait   = r_wait;
        n_tline  = r_tline;
        n_tcol   = r_tcol;
        n_total  = r_total;
        n_buf    = r_buf;
        n_modarg = r_modarg;
        n_prod   = r_prod;
        n_qd     = r_qd;
        n_wanted = r_wanted;
        n_exec   = r_exec;
        n_wr     = r_wr;
        n_wa     = r_wa;
        n_wv     = r_wv;

        if (!r_active) begin
            if (w_accept) begin
                n_active = 1'b1;
                n_step   = dlc_pkg::ST_DISP;
            end
        end else begin
            case (w_uw.op)
                dlc_pkg::U_BEGIN: begin
                    n_wanted = 1'b0;
                    n_exec   = 1'b0;
                    n_wr     = 1'b0;
                    n_wa     = '0;
                    n_wv     = '0;
                end
                dlc_pkg::U_CLEAR: begin
                    n_pc    = '0;
                    n_idx   = '0;
                    n_en    = 1'b0;
                    n_wait  = 1'b0;
                    n_tline = '0;
                    n_tcol  = '0;
                    n_total = '0;
                end
                dlc_pkg::U_START: begin
                    n_pc     = r_addr;
                    n_en     = 1'b1;
                    n_wait   = 1'b0;
                    n_modarg = r_addr;
                end
                dlc_pkg::U_LDARG: n_modarg = r_addr;
                dlc_pkg::U_MUL1:  n_prod   = 49'(r_modarg) * 49'(RECIP);
                dlc_pkg::U_MUL2:  n_qd     = w_qd_full[23:0];
                dlc_pkg::U_MODFIN: begin
                    // a load keeps the fetch index on the program counter
                    if (r_act == dlc_pkg::ACT_LOAD) begin
                        n_widx = AW'(r_modarg - r_qd);
                    end else begin
                        n_idx = AW'(r_modarg - r_qd);
                    end
                end
                dlc_pkg::U_SLOT:  n_wanted = r_en && (!r_wait || w_slot_reached);
                dlc_pkg::U_OPCODE: begin
                    n_exec  = 1'b1;
                    n_wait  = 1'b0;
                    n_total = r_total + 32'd1;
                    n_pc    = r_pc + 24'd1;
                    n_idx   = w_idx_inc;
                end
                dlc_pkg::U_STOP:  n_en = 1'b0;
                dlc_pkg::U_TAKE: begin
                    n_buf = {r_rdata, r_buf[23:8]};
                    n_pc  = r_pc + 24'd1;
                    n_idx = w_idx_inc;
                end
                dlc_pkg::U_TAKE_LINE: begin
                    n_tline = r_buf[23:8];
                    n_buf   = {r_rdata, r_buf[23:8]};
                    n_pc    = r_pc + 24'd1;
                    n_idx   = w_idx_inc;
                end
                dlc_pkg::U_WAITFIN: begin
                    n_tcol = r_buf[23:8];
                    n_wait = !w_wait_reached;
                end
                dlc_pkg::U_MOVEFIN: begin
                    n_wa  = r_buf[23:8];
                    n_wv  = r_rdata;
                    n_wr  = 1'b1;
                    n_pc  = r_pc + 24'd1;
                    n_idx = w_idx_inc;
                end
                default: ;
            endcase

            // JUMP target is complete in the buffer once the third byte is taken.
            if (r_step == dlc_pkg::ST_JUMPF) begin
                n_pc     = r_buf;
                n_modarg = r_buf;
            end

            case (w_uw.jmp)
                dlc_pkg::J_NEXT:     n_step = r_step + 1'b1;
                dlc_pkg::J_ALWAYS:   n_step = w_uw.target;
                dlc_pkg::J_CASE_ACT: n_step = w_uw.target + dlc_pkg::STEP_W'(r_act);
                dlc_pkg::J_CASE_OP:  n_step = w_uw.target + dlc_pkg::STEP_W'(w_op_class);
                dlc_pkg::J_IF_NOT_LOAD:
                    n_step = (r_act != dlc_pkg::ACT_LOAD) ? w_uw.target : r_step + 1'b1;
                dlc_pkg::J_IF_UNWANTED:
                    n_step = !r_wanted ? w_uw.target : r_step + 1'b1;
                dlc_pkg::J_RETIRE: begin
                    n_active = 1'b0;
                    n_step   = w_uw.target;
                end
                default: n_step = dlc_pkg::ST_DONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_step   <= dlc_pkg::ST_DISP;
            r_pc     <= '0;
            r_idx    <= '0;
            r_en     <= 1'b0;
            r_wait   <= 1'b0;
            r_tline  <= '0;
            r_tcol   <= '0;
            r_total  <= '0;
            r_wanted <= 1'b0;
            r_exec   <= 1'b0;
            r_wr     <= 1'b0;
            r_wa     <= '0;
            r_wv     <= '0;
        end else begin
            r_active <= n_active;
            r_step   <= n_step;
            r_pc     <= n_pc;
            r_idx    <= n_idx;
            r_en     <= n_en;
            r_wait   <= n_wait;
            r_tline  <= n_tline;
            r_tcol   <= n_tcol;
            r_total  <= n_total;
            r_wanted <= n_wanted;
            r_exec   <= n_exec;
            r_wr     <= n_wr;
            r_wa     <= n_wa;
            r_wv     <= n_wv;
        end
        r_widx   <= n_widx;
        r_buf    <= n_buf;
        r_modarg <= n_modarg;
        r_prod   <= n_prod;
        r_qd     <= n_qd;
        if (w_accept) begin
            r_act  <= i_action;
            r_bx   <= i_beam_x;
            r_by   <= i_beam_y;
            r_addr <= i_address;
            r_lb   <= i_load_byte;
        end
    end

    // Read ahead at the next index so the byte under the program counter is always ready.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_widx] <= r_lb;
        end
        r_rdata <= r_mem[n_idx];
    end

    assign busy                = r_active;
    assign o_done              = r_active && (r_step == dlc_pkg::ST_DONE);
    assign o_slot_wanted       = r_wanted;
    assign o_executed          = r_exec;
    assign o_write_valid       = r_wr;
    assign o_write_address     = r_wa;
    assign o_write_value       = r_wv;
    assign o_running           = r_en;
    assign o_holding           = r_wait;
    assign o_program_counter   = r_pc;
    assign o_instruction_count = r_total;

    a_done_retires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("sequencer still busy after o_done");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && r_step == dlc_pkg::ST_DISP))
        else $error("accepted request did not enter dispatch");

    a_write_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_write_valid) |-> (o_executed && o_slot_wanted))
        else $error("MOVE write without an executed instruction");

    a_exec_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && w_uw.op == dlc_pkg::U_OPCODE) |=> (r_total == $past(r_total) + 32'd1))
        else $error("instruction count did not advance on fetch");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_LAST)
        else $error("store index beyond program depth");

endmodule
